// ===== rtl/texture_address_sampler_macros.svh =====
// Assertion macros for the texture address sampler.
// Used by the queue and the back end; expects clk_i and rst_ni in scope.
`ifndef TEXTURE_ADDRESS_SAMPLER_MACROS_SVH
`define TEXTURE_ADDRESS_SAMPLER_MACROS_SVH

`ifndef SYNTHESIS
`define TAS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define TAS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TAS_ASSERT(label, cond, msg)
`define TAS_ASSERT_IMPL(label, ante, cons, msg)
`define TAS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/tas_pkg.sv =====
// Shared types and constants of the texture address sampler.
// No dependencies; imported by the top level, the front end and the back end.
`default_nettype none

package tas_pkg;

  typedef enum logic {
    ACT_STORE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } tas_action_e;

  typedef enum logic [1:0] {
    MODE_BORDER = 2'd0,
    MODE_CLAMP  = 2'd1,
    MODE_WRAP   = 2'd2,
    MODE_MIRROR = 2'd3
  } tas_mode_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } tas_reg_e;

  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] BORDER_R = 8'd255;
  localparam logic [7:0] BORDER_G = 8'd105;
  localparam logic [7:0] BORDER_B = 8'd180;

  typedef struct packed {
    logic               action;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
    logic [1:0]         address_mode;
  } tas_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       border_hit;
  } tas_rsp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tas_color_t;

  // Classified operation handed from the front end to the back end
  typedef struct packed {
    logic       sample;
    logic       border;
    logic       wr_ok;
    tas_color_t color;
  } tas_op_t;

  // Zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input int unsigned maxv);
    if (r == '0) return SIZE_W'(1);
    if (32'(r) > maxv) return maxv[SIZE_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/texture_address_sampler.sv =====
// Texture address sampler: one store or sample request per cycle when not stalled.
// Sample path: a taken request passes the queue, then index multiply, address, texel
// RAM read and output register; stores return nothing. Throughput is one request
// per cycle when not stalled, set by the one RAM port used at most once per request.
// Reset clears control state and sets both sizes to 256 (capped at the maximum);
// texel memory is not cleared and holds garbage until written.
`default_nettype none

module texture_address_sampler #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  output logic                            req_ready_o,
  input  wire tas_pkg::tas_req_t          req_i,
  output logic                            rsp_valid_o,
  input  wire logic                       rsp_ready_i,
  output tas_pkg::tas_rsp_t               rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire tas_pkg::tas_reg_e          cfg_idx_i,
  input  wire logic [tas_pkg::SIZE_W-1:0] cfg_data_i
);

  import tas_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CRD_W = FRAC_BITS + 1;
  localparam int unsigned QW    = $bits(tas_op_t) + AW + 2 * CRD_W;
  localparam logic [SIZE_W-1:0] W_RST = eff_size(SIZE_W'(256), MAX_WIDTH);
  localparam logic [SIZE_W-1:0] H_RST = eff_size(SIZE_W'(256), MAX_HEIGHT);

  logic [SIZE_W-1:0] w_q, h_q;

  tas_op_t          f_op, b_op;
  logic [AW-1:0]    f_addr, b_addr;
  logic [CRD_W-1:0] f_u, f_v, b_u, b_v;
  logic [QW-1:0]    q_wdata, q_rdata;
  logic             q_valid;
  logic             q_pop;

  // Sizes are kept already limited to the legal range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_RST;
      h_q <= H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEX_WIDTH:  w_q <= eff_size(cfg_data_i, MAX_WIDTH);
        REG_TEX_HEIGHT: h_q <= eff_size(cfg_data_i, MAX_HEIGHT);
      endcase
    end
  end

  tas_front #(
    .FRAC_BITS(FRAC_BITS),
    .DEPTH    (DEPTH),
    .AW       (AW)
  ) u_front (
    .req_i (req_i),
    .w_i   (w_q),
    .h_i   (h_q),
    .op_o  (f_op),
    .addr_o(f_addr),
    .u_o   (f_u),
    .v_o   (f_v)
  );

  assign q_wdata = {f_op, f_addr, f_u, f_v};

  tas_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(req_valid_i),
    .push_ready_o(req_ready_o),
    .push_data_i (q_wdata),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata)
  );

  assign {b_op, b_addr, b_u, b_v} = q_rdata;

  tas_back #(
    .FRAC_BITS(FRAC_BITS),
    .DEPTH    (DEPTH),
    .AW       (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .op_i       (b_op),
    .addr_i     (b_addr),
    .u_i        (b_u),
    .v_i        (b_v),
    .w_i        (w_q),
    .h_i        (h_q),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tas_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tas_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tas_front.sv =====
// Front end: classifies store and sample requests, computes store addresses,
// folds sample coordinates by address mode and flags border hits. Uses tas_pkg.
`default_nettype none

module tas_front #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEPTH     = 65536,
  parameter int unsigned AW        = 16
) (
  input  wire tas_pkg::tas_req_t          req_i,
  input  wire logic [tas_pkg::SIZE_W-1:0] w_i,
  input  wire logic [tas_pkg::SIZE_W-1:0] h_i,
  output tas_pkg::tas_op_t             op_o,
  output logic [AW-1:0]                addr_o,
  output logic [FRAC_BITS:0]           u_o,
  output logic [FRAC_BITS:0]           v_o
);

  import tas_pkg::*;

  localparam int unsigned CRD_W = FRAC_BITS + 1;
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] TWO   = ONE <<< 1;
  localparam logic signed [31:0] MASK1 = ONE - 32'sd1;
  localparam logic signed [31:0] MASK2 = TWO - 32'sd1;

  // Bring a coordinate into [0,1]; border mode passes it through
  function automatic logic [CRD_W-1:0] fold(input logic signed [31:0] c, input tas_mode_e m);
    logic signed [31:0] t;
    t = c;
    unique case (m)
      MODE_BORDER: t = c;
      MODE_CLAMP: begin
        if (c < 0) t = '0;
        else if (c > ONE) t = ONE;
        else t = c;
      end
      MODE_WRAP: begin
        if (c > ONE) t = ((c - 32'sd1) & MASK1) + 32'sd1;
        else if (c < 0) t = c & MASK1;
        else t = c;
      end
      MODE_MIRROR: begin
        if (c > TWO) t = ((c - 32'sd1) & MASK2) + 32'sd1;
        else if (c < 0) t = c & MASK2;
        else t = c;
        if (t > ONE) t = TWO - t;
      end
    endcase
    return t[CRD_W-1:0];
  endfunction

  tas_mode_e   mode;
  logic        is_sample;
  logic        outside;
  logic        x_ok;
  logic        y_ok;
  logic [17:0] st_addr;

  assign mode      = tas_mode_e'(req_i.address_mode);
  assign is_sample = (req_i.action == ACT_SAMPLE);
  assign outside   = (req_i.coord_u < 0) || (req_i.coord_u > ONE) ||
                     (req_i.coord_v < 0) || (req_i.coord_v > ONE);

  assign x_ok    = ({1'b0, req_i.texel_x} < w_i);
  assign y_ok    = ({1'b0, req_i.texel_y} < h_i);
  assign st_addr = 18'(req_i.texel_y) * 18'(w_i) + 18'(req_i.texel_x);

  always_comb begin
    op_o.sample      = is_sample;
    op_o.border      = is_sample && (mode == MODE_BORDER) && outside;
    op_o.wr_ok       = !is_sample && x_ok && y_ok && (32'(st_addr) < 32'(DEPTH));
    op_o.color.red   = req_i.in_red;
    op_o.color.green = req_i.in_green;
    op_o.color.blue  = req_i.in_blue;
  end

  assign addr_o = AW'(st_addr);
  assign u_o    = fold(req_i.coord_u, mode);
  assign v_o    = fold(req_i.coord_v, mode);

endmodule

`default_nettype wire

// ===== rtl/tas_queue.sv =====
// Short register-based FIFO between the front end and the back end.
// No package dependencies; asserts through the block's macro header.
`default_nettype none
`include "texture_address_sampler_macros.svh"

module tas_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    else if (!push && pop_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TAS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `TAS_ASSERT_IMPL(a_pop_nonempty, pop_i, cnt_q != '0, "pop from empty queue")
  `TAS_ASSERT_NEXT(a_cnt_fill, push && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1), "count lost a push")

endmodule

`default_nettype wire

// ===== rtl/tas_back.sv =====
// Back end: scales folded coordinates to texel indexes, forms the address,
// accesses the texel RAM and registers the result. Uses tas_pkg and tas_ram.
`default_nettype none
`include "texture_address_sampler_macros.svh"

module tas_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEPTH     = 65536,
  parameter int unsigned AW        = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  output logic                            q_pop_o,
  input  wire tas_pkg::tas_op_t           op_i,
  input  wire logic [AW-1:0]              addr_i,
  input  wire logic [FRAC_BITS:0]         u_i,
  input  wire logic [FRAC_BITS:0]         v_i,
  input  wire logic [tas_pkg::SIZE_W-1:0] w_i,
  input  wire logic [tas_pkg::SIZE_W-1:0] h_i,
  output logic                            rsp_valid_o,
  input  wire logic                       rsp_ready_i,
  output tas_pkg::tas_rsp_t               rsp_o
);

  import tas_pkg::*;

  localparam int unsigned CRD_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W = CRD_W + SIZE_W;

  logic adv;

  // Stage 1: index multiply
  logic [PROD_W-1:0] prod_u, prod_v;
  logic [SIZE_W-1:0] iu_raw, iv_raw, iu_d, iv_d;
  logic              v1_q;
  tas_op_t           op1_q;
  logic [AW-1:0]     addr1_q;
  logic [SIZE_W-1:0] iu1_q, iv1_q;

  // Stage 2: address
  logic [17:0]       smp_full;
  logic              smp_ok;
  logic              v2_q;
  tas_op_t           op2_q;
  logic [AW-1:0]     addr2_q;
  logic              rdok2_q;

  // Stage 3: RAM data
  logic              v3_q;
  tas_op_t           op3_q;
  logic              rdok3_q;
  logic              ram_en;
  logic              ram_we;
  tas_color_t        ram_rdata;

  // Output register
  logic              out_valid_q;
  tas_rsp_t          out_q;

  // Whole back end moves together; stall only on a held result
  assign adv     = !out_valid_q || rsp_ready_i;
  assign q_pop_o = adv && q_valid_i;

  assign prod_u = PROD_W'(u_i) * PROD_W'(w_i - SIZE_W'(1));
  assign prod_v = PROD_W'(v_i) * PROD_W'(h_i - SIZE_W'(1));
  assign iu_raw = prod_u[FRAC_BITS +: SIZE_W];
  assign iv_raw = prod_v[FRAC_BITS +: SIZE_W];
  assign iu_d   = (iu_raw > w_i - SIZE_W'(1)) ? w_i - SIZE_W'(1) : iu_raw;
  assign iv_d   = (iv_raw > h_i - SIZE_W'(1)) ? h_i - SIZE_W'(1) : iv_raw;

  assign smp_full = 18'(iv1_q) * 18'(w_i) + 18'(iu1_q);
  assign smp_ok   = (32'(smp_full) < 32'(DEPTH));

  assign ram_we = !op2_q.sample;
  assign ram_en = adv && v2_q && (op2_q.sample ? (!op2_q.border && rdok2_q) : op2_q.wr_ok);

  tas_ram #(
    .WIDTH($bits(tas_color_t)),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (addr2_q),
    .wdata_i(op2_q.color),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q && op3_q.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= op_i;
      addr1_q <= addr_i;
      iu1_q   <= iu_d;
      iv1_q   <= iv_d;

      op2_q   <= op1_q;
      addr2_q <= op1_q.sample ? AW'(smp_full) : addr1_q;
      rdok2_q <= op1_q.sample ? smp_ok : 1'b1;

      op3_q   <= op2_q;
      rdok3_q <= rdok2_q;

      if (op3_q.border) begin
        out_q.out_red    <= BORDER_R;
        out_q.out_green  <= BORDER_G;
        out_q.out_blue   <= BORDER_B;
        out_q.border_hit <= 1'b1;
      end else begin
        out_q.out_red    <= rdok3_q ? ram_rdata.red   : '0;
        out_q.out_green  <= rdok3_q ? ram_rdata.green : '0;
        out_q.out_blue   <= rdok3_q ? ram_rdata.blue  : '0;
        out_q.border_hit <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `TAS_ASSERT_NEXT(a_sample_out, adv && v3_q && op3_q.sample, out_valid_q, "sample result dropped")
  `TAS_ASSERT_IMPL(a_border_pink, out_valid_q && out_q.border_hit,
                   out_q.out_green == BORDER_G && out_q.out_blue == BORDER_B,
                   "border color wrong")

endmodule

`default_nettype wire
